FILE: design/tdps_pkg.sv
// ----------------------------------------------------------------------------
// tdps_pkg
// Shared constants, codes and controller/datapath interface types for the
// triangle depth pixel shader.
// ----------------------------------------------------------------------------
package tdps_pkg;

  localparam int MAX_TRIANGLES_DEF = 256;
  localparam int COORD_WIDTH_DEF   = 24;

  // request codes
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_SHADE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BG     = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int COLOR_W    = 24;
  localparam int POS_W      = 12;
  localparam int SIZE_W     = 13;
  localparam logic [SIZE_W-1:0] SIZE_MAX   = 13'd4096;
  localparam logic [SIZE_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd480;

  localparam int NZ_W = 16;
  // culled when -normal_z > 0.8 in Q1.14
  localparam logic signed [NZ_W-1:0] CULL_NZ = -16'sd13108;

  localparam int Q16_ONE = 65536;
  localparam int E_MIN   = 4;      // edge-on limit, 1e-9 in Q.32

  // shared divider
  localparam int DIV_N_W = 54;
  localparam int DIV_D_W = 30;
  localparam int DIV_Q_W = 24;

  localparam int RAY_W = 25;       // ray x/y, Q.16, saturated past the coordinate range
  localparam int NN_W  = 30;       // normalized barycentric terms
  localparam int DZ_W  = 19;       // z deltas
  localparam int NUM_W = 50;       // depth numerator terms
  localparam int ZW    = 20;       // interpolated depth

  // product select codes
  localparam logic [2:0] MUL_QBX_QCY = 3'd0;
  localparam logic [2:0] MUL_QBY_QCX = 3'd1;
  localparam logic [2:0] MUL_PX_QCY  = 3'd2;
  localparam logic [2:0] MUL_PY_QCX  = 3'd3;
  localparam logic [2:0] MUL_QBX_PY  = 3'd4;
  localparam logic [2:0] MUL_QBY_PX  = 3'd5;

  typedef struct packed {
    logic       clear;
    logic       load;
    logic       shade_init;
    logic       div_rx;
    logic       div_ry;
    logic       div_z;
    logic       rx_take;
    logic       ry_take;
    logic       rd;
    logic       box;
    logic       mul_en;
    logic [2:0] mul_sel;
    logic       diff;
    logic       fix;
    logic       norm;
    logic       num0;
    logic       num1;
    logic       sum;
    logic       z_upd;
    logic       next_tri;
    logic       out;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic no_tris;
    logic last_tri;
    logic box_ok;
    logic tri_ok;
    logic norm_done;
  } dp_stat_t;

endpackage

FILE: design/tdps_ram.sv
// ----------------------------------------------------------------------------
// tdps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tdps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/tdps_div.sv
// ----------------------------------------------------------------------------
// tdps_div
// Unsigned restoring divider, one quotient bit per cycle. The caller
// guarantees the quotient fits DIV_Q_W bits.
// ----------------------------------------------------------------------------
module tdps_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tdps_pkg::DIV_N_W-1:0] dividend,
  input  logic [tdps_pkg::DIV_D_W-1:0] divisor,
  output logic [tdps_pkg::DIV_Q_W-1:0] quotient,
  output logic                        done
);

  localparam int NW = tdps_pkg::DIV_N_W;
  localparam int QW = tdps_pkg::DIV_Q_W;
  localparam int CW = $clog2(QW + 1);

  logic [NW-1:0] rem;
  logic [NW-1:0] dsh;
  logic [CW-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= dividend;
        dsh <= NW'(divisor) << (QW - 1);
        cnt <= CW'(QW);
      end else if (cnt != '0) begin
        if (rem >= dsh) begin
          rem      <= rem - dsh;
          quotient <= {quotient[QW-2:0], 1'b1};
        end else begin
          quotient <= {quotient[QW-2:0], 1'b0};
        end
        dsh  <= dsh >> 1;
        cnt  <= cnt - CW'(1);
        done <= (cnt == CW'(1));
      end
    end
  end

endmodule

FILE: design/tdps_dp.sv
// ----------------------------------------------------------------------------
// tdps_dp
// Datapath: config registers, triangle store, pixel walk, per-triangle
// edge products, normalization, depth interpolation and depth test.
// ----------------------------------------------------------------------------
module tdps_dp #(
  parameter int MAX_TRIANGLES = tdps_pkg::MAX_TRIANGLES_DEF,
  parameter int COORD_WIDTH   = tdps_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  tdps_pkg::dp_cmd_t                   cmd,
  output tdps_pkg::dp_stat_t                  stat,
  input  logic                                cfg_write,
  input  logic [tdps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tdps_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic signed [COORD_WIDTH-1:0]       vertex_ax,
  input  logic signed [COORD_WIDTH-1:0]       vertex_ay,
  input  logic signed [COORD_WIDTH-1:0]       vertex_az,
  input  logic signed [COORD_WIDTH-1:0]       vertex_bx,
  input  logic signed [COORD_WIDTH-1:0]       vertex_by,
  input  logic signed [COORD_WIDTH-1:0]       vertex_bz,
  input  logic signed [COORD_WIDTH-1:0]       vertex_cx,
  input  logic signed [COORD_WIDTH-1:0]       vertex_cy,
  input  logic signed [COORD_WIDTH-1:0]       vertex_cz,
  input  logic [tdps_pkg::COLOR_W-1:0]        surface_color,
  input  logic signed [tdps_pkg::NZ_W-1:0]    normal_z,
  output logic [tdps_pkg::COLOR_W-1:0]        pixel_color,
  output logic [tdps_pkg::POS_W-1:0]          pixel_row,
  output logic [tdps_pkg::POS_W-1:0]          pixel_column,
  output logic                                covered,
  output logic                                done
);

  localparam int CW    = COORD_WIDTH;
  localparam int AW    = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int CNT_W = $clog2(MAX_TRIANGLES + 1);
  localparam int DX_W  = CW + 2;
  localparam int PW    = 2 * DX_W;
  localparam int EW    = PW + 1;
  localparam int TW    = 9 * CW + tdps_pkg::COLOR_W;
  localparam int SW    = tdps_pkg::SIZE_W;
  localparam int RW    = tdps_pkg::RAY_W;
  localparam int ZW    = tdps_pkg::ZW;
  localparam int NUMW  = tdps_pkg::NUM_W;
  localparam int NNW   = tdps_pkg::NN_W;
  localparam int DZW   = tdps_pkg::DZ_W;
  localparam int QW    = tdps_pkg::DIV_Q_W;
  localparam int NW    = tdps_pkg::DIV_N_W;
  localparam int DW    = tdps_pkg::DIV_D_W;

  localparam logic signed [DX_W-1:0] ONE   = DX_W'(tdps_pkg::Q16_ONE);
  localparam logic signed [EW-1:0]   E_LIM = EW'(tdps_pkg::E_MIN);

  function automatic logic in_unit(input logic signed [DX_W-1:0] v);
    in_unit = (v >= -ONE) && (v <= ONE);
  endfunction

  // config and walk state
  logic [SW-1:0] scr_w, scr_h, w_c, h_c;
  logic [tdps_pkg::COLOR_W-1:0] bg;
  logic [CNT_W-1:0] count;
  logic [tdps_pkg::POS_W-1:0] row, col;
  logic [AW-1:0] idx;

  assign w_c = (scr_w == '0) ? SW'(1) : ((scr_w > tdps_pkg::SIZE_MAX) ? tdps_pkg::SIZE_MAX : scr_w);
  assign h_c = (scr_h == '0) ? SW'(1) : ((scr_h > tdps_pkg::SIZE_MAX) ? tdps_pkg::SIZE_MAX : scr_h);

  // load filter
  logic keep, store_we;
  logic in_a, in_b, in_c, z_ok;
  assign in_a = in_unit(DX_W'(vertex_ax)) && in_unit(DX_W'(vertex_ay));
  assign in_b = in_unit(DX_W'(vertex_bx)) && in_unit(DX_W'(vertex_by));
  assign in_c = in_unit(DX_W'(vertex_cx)) && in_unit(DX_W'(vertex_cy));
  assign z_ok = in_unit(DX_W'(vertex_az)) && in_unit(DX_W'(vertex_bz))
             && in_unit(DX_W'(vertex_cz));
  assign keep = (normal_z > tdps_pkg::CULL_NZ) && z_ok && (in_a || in_b || in_c);
  assign store_we = cmd.load && keep && (count < CNT_W'(MAX_TRIANGLES));

  logic [TW-1:0] wdata, rdata;
  assign wdata = {surface_color, vertex_cz, vertex_cy, vertex_cx,
                  vertex_bz, vertex_by, vertex_bx, vertex_az, vertex_ay, vertex_ax};

  tdps_ram #(.WIDTH(TW), .DEPTH(MAX_TRIANGLES)) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (count[AW-1:0]),
    .wdata (wdata),
    .re    (cmd.rd),
    .raddr (idx),
    .rdata (rdata)
  );

  // stored word fields
  logic signed [DX_W-1:0] tx [3];
  logic signed [DX_W-1:0] ty [3];
  logic signed [DX_W-1:0] tz [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tx[k] = DX_W'($signed(rdata[(3*k)*CW +: CW]));
      ty[k] = DX_W'($signed(rdata[(3*k+1)*CW +: CW]));
      tz[k] = DX_W'($signed(rdata[(3*k+2)*CW +: CW]));
    end
  end

  // ray and divider
  logic signed [RW-1:0] rx, ry;
  logic signed [SW+1:0] rx_num, ry_num;
  logic [SW:0] rx_mag, ry_mag;
  assign rx_num = $signed({2'b00, col, 1'b0}) - $signed({2'b00, w_c});
  assign ry_num = $signed({2'b00, h_c}) - $signed({2'b00, row, 1'b0});
  assign rx_mag = rx_num[SW+1] ? (SW+1)'(-rx_num) : (SW+1)'(rx_num);
  assign ry_mag = ry_num[SW+1] ? (SW+1)'(-ry_num) : (SW+1)'(ry_num);

  // a quotient of 2^QW or more lies past every coordinate; saturate it
  logic rx_sat, ry_sat;
  assign rx_sat = ({7'b0, rx_mag} >= {w_c, 8'b0});
  assign ry_sat = ({7'b0, ry_mag} >= {h_c, 8'b0});

  logic [NW-1:0] div_n;
  logic [DW-1:0] div_d;
  logic [QW-1:0] div_q;
  logic [QW-1:0] rx_q, ry_q;
  logic          div_done;
  logic          num_neg;
  logic [NW-1:0] num_abs;
  logic signed [EW-1:0] e_v, n1_v, n2_v;

  assign rx_q = rx_sat ? '1 : div_q;
  assign ry_q = ry_sat ? '1 : div_q;

  always_comb begin
    div_n = num_abs;
    div_d = e_v[DW-1:0];
    if (cmd.div_rx) begin
      div_n = NW'({rx_mag, 16'b0});
      div_d = DW'(w_c);
    end else if (cmd.div_ry) begin
      div_n = NW'({ry_mag, 16'b0});
      div_d = DW'(h_c);
    end
  end

  tdps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_rx || cmd.div_ry || cmd.div_z),
    .dividend (div_n),
    .divisor  (div_d),
    .quotient (div_q),
    .done     (div_done)
  );

  // per-triangle registers
  logic signed [DX_W-1:0] qbx, qby, qcx, qcy, px, py;
  logic signed [DZW-1:0]  dz1, dz2;
  logic signed [ZW-1:0]   az_r;
  logic [tdps_pkg::COLOR_W-1:0] tcolor;
  logic box_ok;
  logic signed [PW-1:0] prod [6];
  logic signed [DX_W-1:0] ma, mb;
  logic signed [NUMW-1:0] m0, m1;
  logic signed [NUMW:0] num_sum;
  logic signed [DX_W-1:0] rxw, ryw;
  logic out_x, out_y, box_hit;
  logic signed [DX_W-1:0] dz1w, dz2w;

  assign rxw = DX_W'(rx);
  assign ryw = DX_W'(ry);
  assign out_x = ((rxw < tx[0]) && (rxw < tx[1]) && (rxw < tx[2]))
              || ((rxw > tx[0]) && (rxw > tx[1]) && (rxw > tx[2]));
  assign out_y = ((ryw < ty[0]) && (ryw < ty[1]) && (ryw < ty[2]))
              || ((ryw > ty[0]) && (ryw > ty[1]) && (ryw > ty[2]));
  assign box_hit = !out_x && !out_y;
  assign dz1w = tz[1] - tz[0];
  assign dz2w = tz[2] - tz[0];

  always_comb begin
    case (cmd.mul_sel)
      tdps_pkg::MUL_QBX_QCY: begin ma = qbx; mb = qcy; end
      tdps_pkg::MUL_QBY_QCX: begin ma = qby; mb = qcx; end
      tdps_pkg::MUL_PX_QCY:  begin ma = px;  mb = qcy; end
      tdps_pkg::MUL_PY_QCX:  begin ma = py;  mb = qcx; end
      tdps_pkg::MUL_QBX_PY:  begin ma = qbx; mb = py;  end
      tdps_pkg::MUL_QBY_PX:  begin ma = qby; mb = px;  end
      default:               begin ma = '0;  mb = '0;  end
    endcase
  end

  // inside test on sign-corrected terms
  logic signed [EW:0] n_sum;
  assign n_sum = (EW+1)'(n1_v) + (EW+1)'(n2_v);
  assign num_sum = (NUMW+1)'(m0) + (NUMW+1)'(m1);

  // depth of this hit
  logic signed [ZW-1:0] zq, z_new, zbest;
  logic hit;
  logic [tdps_pkg::COLOR_W-1:0] win_color;
  assign zq = num_neg ? -ZW'(div_q) : ZW'(div_q);
  assign z_new = az_r + zq;

  always_ff @(posedge clk) begin
    if (rst) begin
      scr_w   <= tdps_pkg::WIDTH_RST;
      scr_h   <= tdps_pkg::HEIGHT_RST;
      bg      <= '0;
      count   <= '0;
      row     <= '0;
      col     <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        case (cfg_index)
          tdps_pkg::CFG_WIDTH:  scr_w <= cfg_data[SW-1:0];
          tdps_pkg::CFG_HEIGHT: scr_h <= cfg_data[SW-1:0];
          tdps_pkg::CFG_BG:     bg    <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.clear) begin
        count <= '0;
        row   <= '0;
        col   <= '0;
      end
      if (store_we) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.out) begin
        done         <= 1'b1;
        pixel_color  <= win_color;
        pixel_row    <= row;
        pixel_column <= col;
        covered      <= hit;
        if (({1'b0, col} + SW'(1)) >= w_c) begin
          col <= '0;
          row <= (({1'b0, row} + SW'(1)) >= h_c) ? '0 : row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shade_init) begin
      hit       <= 1'b0;
      win_color <= bg;
      idx       <= '0;
    end
    if (cmd.next_tri) begin
      idx <= idx + 1'b1;
    end
    if (cmd.rx_take) begin
      rx <= rx_num[SW+1] ? -RW'(rx_q) : RW'(rx_q);
    end
    if (cmd.ry_take) begin
      ry <= ry_num[SW+1] ? -RW'(ry_q) : RW'(ry_q);
    end
    if (cmd.box) begin
      box_ok <= box_hit;
      qbx    <= tx[1] - tx[0];
      qby    <= ty[1] - ty[0];
      qcx    <= tx[2] - tx[0];
      qcy    <= ty[2] - ty[0];
      px     <= rxw - tx[0];
      py     <= ryw - ty[0];
      dz1    <= dz1w[DZW-1:0];
      dz2    <= dz2w[DZW-1:0];
      az_r   <= ZW'(tz[0]);
      tcolor <= rdata[TW-1 -: tdps_pkg::COLOR_W];
    end
    if (cmd.mul_en) begin
      prod[cmd.mul_sel] <= ma * mb;
    end
    if (cmd.diff) begin
      e_v  <= EW'(prod[0]) - EW'(prod[1]);
      n1_v <= EW'(prod[2]) - EW'(prod[3]);
      n2_v <= EW'(prod[4]) - EW'(prod[5]);
    end
    if (cmd.fix && e_v[EW-1]) begin
      e_v  <= -e_v;
      n1_v <= -n1_v;
      n2_v <= -n2_v;
    end
    // shift toward a 30-bit e; shifts compose, so 8 then 1 at a time is exact
    if (cmd.norm) begin
      if ((e_v >> 38) != '0) begin
        e_v  <= e_v >> 8;
        n1_v <= n1_v >> 8;
        n2_v <= n2_v >> 8;
      end else if ((e_v >> 30) != '0) begin
        e_v  <= e_v >> 1;
        n1_v <= n1_v >> 1;
        n2_v <= n2_v >> 1;
      end
    end
    if (cmd.num0) begin
      m0 <= $signed({1'b0, n1_v[NNW-1:0]}) * dz1;
    end
    if (cmd.num1) begin
      m1 <= $signed({1'b0, n2_v[NNW-1:0]}) * dz2;
    end
    if (cmd.sum) begin
      num_neg <= num_sum[NUMW];
      num_abs <= num_sum[NUMW] ? NW'(-num_sum) : NW'(num_sum);
    end
    if (cmd.z_upd && (!hit || (z_new <= zbest))) begin
      hit       <= 1'b1;
      zbest     <= z_new;
      win_color <= tcolor;
    end
  end

  always_comb begin
    stat.div_done  = div_done;
    stat.no_tris   = (count == '0);
    stat.last_tri  = ((CNT_W'(idx) + CNT_W'(1)) == count);
    stat.box_ok    = box_ok;
    stat.tri_ok    = (e_v > E_LIM) && !n1_v[EW-1] && !n2_v[EW-1]
                  && (n_sum <= (EW+1)'(e_v));
    stat.norm_done = ((e_v >> 30) == '0);
  end

endmodule

FILE: design/tdps_ctrl.sv
// ----------------------------------------------------------------------------
// tdps_ctrl
// Controller: decodes requests and sequences ray setup and the per-triangle
// test steps over the datapath.
// ----------------------------------------------------------------------------
module tdps_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         req_type,
  input  tdps_pkg::dp_stat_t stat,
  output tdps_pkg::dp_cmd_t  cmd,
  output logic               busy
);

  typedef enum logic [4:0] {
    S_IDLE, S_RX_GO, S_RX_WAIT, S_RY_GO, S_RY_WAIT, S_RD, S_BOX, S_BTEST,
    S_MUL, S_DIFF, S_FIX, S_TEST, S_NORM, S_NUM0, S_NUM1, S_SUM, S_Z_GO,
    S_Z_WAIT, S_ZUPD, S_NEXT, S_OUT
  } state_t;

  state_t     state;
  logic [2:0] mul_cnt;
  logic       accept;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      busy    <= 1'b0;
      mul_cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && (req_type == tdps_pkg::REQ_SHADE)) begin
            state <= S_RX_GO;
            busy  <= 1'b1;
          end
        end
        S_RX_GO:   state <= S_RX_WAIT;
        S_RX_WAIT: if (stat.div_done) state <= S_RY_GO;
        S_RY_GO:   state <= S_RY_WAIT;
        S_RY_WAIT: begin
          if (stat.div_done) state <= stat.no_tris ? S_OUT : S_RD;
        end
        S_RD:  state <= S_BOX;
        S_BOX: state <= S_BTEST;
        S_BTEST: begin
          mul_cnt <= '0;
          state   <= stat.box_ok ? S_MUL : S_NEXT;
        end
        S_MUL: begin
          mul_cnt <= mul_cnt + 3'd1;
          if (mul_cnt == tdps_pkg::MUL_QBY_PX) state <= S_DIFF;
        end
        S_DIFF: state <= S_FIX;
        S_FIX:  state <= S_TEST;
        S_TEST: state <= stat.tri_ok ? S_NORM : S_NEXT;
        S_NORM: if (stat.norm_done) state <= S_NUM0;
        S_NUM0: state <= S_NUM1;
        S_NUM1: state <= S_SUM;
        S_SUM:  state <= S_Z_GO;
        S_Z_GO: state <= S_Z_WAIT;
        S_Z_WAIT: if (stat.div_done) state <= S_ZUPD;
        S_ZUPD: state <= S_NEXT;
        S_NEXT: state <= stat.last_tri ? S_OUT : S_RD;
        S_OUT: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.mul_sel    = mul_cnt;
    cmd.clear      = accept && (req_type == tdps_pkg::REQ_CLEAR);
    cmd.load       = accept && (req_type == tdps_pkg::REQ_LOAD);
    cmd.shade_init = accept && (req_type == tdps_pkg::REQ_SHADE);
    cmd.div_rx     = (state == S_RX_GO);
    cmd.rx_take    = (state == S_RX_WAIT) && stat.div_done;
    cmd.div_ry     = (state == S_RY_GO);
    cmd.ry_take    = (state == S_RY_WAIT) && stat.div_done;
    cmd.rd         = (state == S_RD);
    cmd.box        = (state == S_BOX);
    cmd.mul_en     = (state == S_MUL);
    cmd.diff       = (state == S_DIFF);
    cmd.fix        = (state == S_FIX);
    cmd.norm       = (state == S_NORM);
    cmd.num0       = (state == S_NUM0);
    cmd.num1       = (state == S_NUM1);
    cmd.sum        = (state == S_SUM);
    cmd.div_z      = (state == S_Z_GO);
    cmd.z_upd      = (state == S_ZUPD);
    cmd.next_tri   = (state == S_NEXT) && !stat.last_tri;
    cmd.out        = (state == S_OUT);
  end

endmodule

FILE: design/triangle_depth_pixel_shader.sv
// ----------------------------------------------------------------------------
// triangle_depth_pixel_shader
// Ray-cast rasterizer with per-pixel depth test over a stored triangle list.
// Shade: ray setup (two divisions of 24 quotient bits), then per stored
// triangle a bounding-box test, an edge-product inside test when the box
// hits, and normalize and depth divide on a hit; then done strobes.
// Clear and load take effect at the accepting edge; busy stays low.
// One shade at a time; done strobes for one cycle as busy drops.
// Synchronous reset: empty store, walk at row 0 column 0, 640x480, black.
// ----------------------------------------------------------------------------
module triangle_depth_pixel_shader #(
  parameter int MAX_TRIANGLES = tdps_pkg::MAX_TRIANGLES_DEF,
  parameter int COORD_WIDTH   = tdps_pkg::COORD_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       req_type,
  input  logic signed [COORD_WIDTH-1:0]    vertex_ax,
  input  logic signed [COORD_WIDTH-1:0]    vertex_ay,
  input  logic signed [COORD_WIDTH-1:0]    vertex_az,
  input  logic signed [COORD_WIDTH-1:0]    vertex_bx,
  input  logic signed [COORD_WIDTH-1:0]    vertex_by,
  input  logic signed [COORD_WIDTH-1:0]    vertex_bz,
  input  logic signed [COORD_WIDTH-1:0]    vertex_cx,
  input  logic signed [COORD_WIDTH-1:0]    vertex_cy,
  input  logic signed [COORD_WIDTH-1:0]    vertex_cz,
  input  logic [tdps_pkg::COLOR_W-1:0]     surface_color,
  input  logic signed [tdps_pkg::NZ_W-1:0] normal_z,
  output logic                             done,
  output logic [tdps_pkg::COLOR_W-1:0]     pixel_color,
  output logic [tdps_pkg::POS_W-1:0]       pixel_row,
  output logic [tdps_pkg::POS_W-1:0]       pixel_column,
  output logic                             covered,
  input  logic                             cfg_write,
  input  logic [tdps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tdps_pkg::CFG_DATA_W-1:0]  cfg_data
);

  tdps_pkg::dp_cmd_t  cmd;
  tdps_pkg::dp_stat_t stat;

  tdps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  tdps_dp #(.MAX_TRIANGLES(MAX_TRIANGLES), .COORD_WIDTH(COORD_WIDTH)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .vertex_ax     (vertex_ax),
    .vertex_ay     (vertex_ay),
    .vertex_az     (vertex_az),
    .vertex_bx     (vertex_bx),
    .vertex_by     (vertex_by),
    .vertex_bz     (vertex_bz),
    .vertex_cx     (vertex_cx),
    .vertex_cy     (vertex_cy),
    .vertex_cz     (vertex_cz),
    .surface_color (surface_color),
    .normal_z      (normal_z),
    .pixel_color   (pixel_color),
    .pixel_row     (pixel_row),
    .pixel_column  (pixel_column),
    .covered       (covered),
    .done          (done)
  );

endmodule

FILE: design/tdps_chk.sv
// ----------------------------------------------------------------------------
// tdps_chk
// Port-level checks on the request/result timing of the shader.
// ----------------------------------------------------------------------------
module tdps_chk (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] req_type,
  input logic       done
);

  a_shade_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req_type == tdps_pkg::REQ_SHADE)) |=> busy)
    else $error("shade word not followed by busy");

  a_other_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req_type != tdps_pkg::REQ_SHADE)) |=> (!busy && !done))
    else $error("non-shade word started work");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result while busy");

  a_fell_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result");

endmodule

bind triangle_depth_pixel_shader tdps_chk u_tdps_chk (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .req_type (req_type),
  .done     (done)
);

FILE: tb/tdps_checker.sv
// ----------------------------------------------------------------------------
// tdps_checker
// Watches the request, result and register ports of the pixel shader. It keeps
// its own triangle list, pixel walk and registers, predicts the color and
// position of every shaded pixel, and compares each result word against the
// oldest prediction.
// ----------------------------------------------------------------------------
module tdps_checker
  import tdps_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [1:0]                    req_type,
  input  logic signed [23:0]            vertex_ax,
  input  logic signed [23:0]            vertex_ay,
  input  logic signed [23:0]            vertex_az,
  input  logic signed [23:0]            vertex_bx,
  input  logic signed [23:0]            vertex_by,
  input  logic signed [23:0]            vertex_bz,
  input  logic signed [23:0]            vertex_cx,
  input  logic signed [23:0]            vertex_cy,
  input  logic signed [23:0]            vertex_cz,
  input  logic [COLOR_W-1:0]            surface_color,
  input  logic signed [NZ_W-1:0]        normal_z,
  input  logic                          done,
  input  logic [COLOR_W-1:0]            pixel_color,
  input  logic [POS_W-1:0]              pixel_row,
  input  logic [POS_W-1:0]              pixel_column,
  input  logic                          covered,
  input  logic                          cfg_write,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  output int                            fail_count,
  output int                            pending
);

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   column;
    logic               hit;
  } pixel_t;

  localparam int NTRI = MAX_TRIANGLES_DEF;

  longint             tx[NTRI][3];
  longint             ty[NTRI][3];
  longint             tz[NTRI][3];
  logic [COLOR_W-1:0] tcolor[NTRI];
  int                 tri_count;
  int                 walk_row;
  int                 walk_col;
  logic [SIZE_W-1:0]  scr_w;
  logic [SIZE_W-1:0]  scr_h;
  logic [COLOR_W-1:0] bg_color;
  pixel_t             pixel_q[$];

  function automatic longint clamp_size(logic [SIZE_W-1:0] v);
    if (v < 1) return 1;
    if (v > SIZE_MAX) return SIZE_MAX;
    return v;
  endfunction

  function automatic bit in_unit(longint v);
    return v >= -Q16_ONE && v <= Q16_ONE;
  endfunction

  // one ray/triangle test; depth returned on a hit
  function automatic bit ray_hit(int i, longint rx, longint ry, output longint z);
    longint lo_x, hi_x, lo_y, hi_y;
    longint qbx, qby, qcx, qcy, px, py, e, n1, n2, v, num;
    int bl, s;
    z = 0;
    lo_x = tx[i][0]; hi_x = tx[i][0]; lo_y = ty[i][0]; hi_y = ty[i][0];
    for (int k = 1; k < 3; k++) begin
      if (tx[i][k] < lo_x) lo_x = tx[i][k];
      if (tx[i][k] > hi_x) hi_x = tx[i][k];
      if (ty[i][k] < lo_y) lo_y = ty[i][k];
      if (ty[i][k] > hi_y) hi_y = ty[i][k];
    end
    if (rx < lo_x || rx > hi_x || ry < lo_y || ry > hi_y) return 0;
    qbx = tx[i][1] - tx[i][0]; qby = ty[i][1] - ty[i][0];
    qcx = tx[i][2] - tx[i][0]; qcy = ty[i][2] - ty[i][0];
    px = rx - tx[i][0]; py = ry - ty[i][0];
    e  = qbx * qcy - qby * qcx;
    n1 = px * qcy - py * qcx;
    n2 = qbx * py - qby * px;
    if (e < 0) begin
      e = -e; n1 = -n1; n2 = -n2;
    end
    if (e <= E_MIN) return 0;  // nearly edge-on
    if (n1 < 0 || n2 < 0 || n1 + n2 > e) return 0;
    bl = 0;
    v = e;
    while (v != 0) begin
      bl++;
      v = v >>> 1;
    end
    s = (bl > 30) ? bl - 30 : 0;
    e = e >>> s; n1 = n1 >>> s; n2 = n2 >>> s;
    num = n1 * (tz[i][1] - tz[i][0]) + n2 * (tz[i][2] - tz[i][0]);
    z = tz[i][0] + num / e;
    return 1;
  endfunction

  task automatic mismatch(string what, longint want, longint got);
    fail_count++;
    if (fail_count <= 10)
      $display("ERROR %s: expected %0h got %0h", what, want, got);
  endtask

  task automatic shade_pixel();
    longint w, h, rx, ry, z, zbest;
    pixel_t px;
    w = clamp_size(scr_w);
    h = clamp_size(scr_h);
    rx = ((2 * longint'(walk_col) - w) * Q16_ONE) / w;
    ry = ((h - 2 * longint'(walk_row)) * Q16_ONE) / h;
    zbest = 0;
    px.color = bg_color;
    px.hit = 0;
    for (int i = 0; i < tri_count; i++) begin
      // ties go to the later triangle
      if (ray_hit(i, rx, ry, z) && (!px.hit || z <= zbest)) begin
        px.hit = 1;
        zbest = z;
        px.color = tcolor[i];
      end
    end
    px.row = walk_row;
    px.column = walk_col;
    pixel_q.push_back(px);
    if (walk_col + 1 >= w) begin
      walk_col = 0;
      walk_row = (walk_row + 1 >= h) ? 0 : walk_row + 1;
    end else begin
      walk_col++;
    end
  endtask

  task automatic load_triangle();
    longint vx[3], vy[3], vz[3];
    bit ok, any_in;
    vx = '{vertex_ax, vertex_bx, vertex_cx};
    vy = '{vertex_ay, vertex_by, vertex_cy};
    vz = '{vertex_az, vertex_bz, vertex_cz};
    ok = normal_z > CULL_NZ;
    any_in = 0;
    for (int k = 0; k < 3; k++) begin
      if (!in_unit(vz[k])) ok = 0;
      if (in_unit(vx[k]) && in_unit(vy[k])) any_in = 1;
    end
    if (ok && any_in && tri_count < NTRI) begin
      tx[tri_count] = vx;
      ty[tri_count] = vy;
      tz[tri_count] = vz;
      tcolor[tri_count] = surface_color;
      tri_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      tri_count = 0;
      walk_row = 0;
      walk_col = 0;
      scr_w = WIDTH_RST;
      scr_h = HEIGHT_RST;
      bg_color = '0;
      pixel_q.delete();
    end else begin
      if (done) begin
        if (pixel_q.size() == 0) begin
          mismatch("result word with nothing expected", 0, pixel_color);
        end else begin
          pixel_t want;
          want = pixel_q.pop_front();
          if (pixel_color !== want.color) mismatch("pixel_color", want.color, pixel_color);
          if (pixel_row !== want.row) mismatch("pixel_row", want.row, pixel_row);
          if (pixel_column !== want.column)
            mismatch("pixel_column", want.column, pixel_column);
          if (covered !== want.hit) mismatch("covered", want.hit, covered);
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_WIDTH:  scr_w = cfg_data[SIZE_W-1:0];
          CFG_HEIGHT: scr_h = cfg_data[SIZE_W-1:0];
          CFG_BG:     bg_color = cfg_data[COLOR_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        case (req_type)
          REQ_CLEAR: begin
            tri_count = 0;
            walk_row = 0;
            walk_col = 0;
          end
          REQ_LOAD:  load_triangle();
          REQ_SHADE: shade_pixel();
          default: ;
        endcase
      end
    end
    pending = pixel_q.size();
  end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the pixel shader with directed and random clear/load/shade words
// under several idle patterns and screen settings; a checker beside the
// block predicts every shaded pixel and counts mismatches.
// ----------------------------------------------------------------------------
module tb_top;
  import tdps_pkg::*;

  localparam int WDOG_LIMIT = 100000;
  localparam int DRAIN = 64;

  typedef struct {
    logic [1:0]         req;
    logic signed [23:0] v[9];  // ax ay az bx by bz cx cy cz
    logic [COLOR_W-1:0] color;
    logic signed [15:0] nz;
  } word_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic [1:0] req_type = REQ_CLEAR;
  logic signed [23:0] vertex_ax = 0, vertex_ay = 0, vertex_az = 0;
  logic signed [23:0] vertex_bx = 0, vertex_by = 0, vertex_bz = 0;
  logic signed [23:0] vertex_cx = 0, vertex_cy = 0, vertex_cz = 0;
  logic [COLOR_W-1:0] surface_color = 0;
  logic signed [NZ_W-1:0] normal_z = 0;
  logic done;
  logic [COLOR_W-1:0] pixel_color;
  logic [POS_W-1:0] pixel_row, pixel_column;
  logic covered;
  logic cfg_write = 0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = 0;
  int fail_count, pending;
  int idle_pct = 0;
  int quiet_cycles = 0;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  triangle_depth_pixel_shader u_dut (.*);

  tdps_checker u_chk (.*);

  // watchdog: cycles with no word moving either way
  always @(posedge clk) begin
    if ((start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("** triangle_depth_pixel_shader: FAILED **");
      $finish;
    end
  end

  task automatic send(word_t w);
    @(negedge clk);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start = 0;
      @(negedge clk);
    end
    req_type = w.req;
    {vertex_ax, vertex_ay, vertex_az} = {w.v[0], w.v[1], w.v[2]};
    {vertex_bx, vertex_by, vertex_bz} = {w.v[3], w.v[4], w.v[5]};
    {vertex_cx, vertex_cy, vertex_cz} = {w.v[6], w.v[7], w.v[8]};
    surface_color = w.color;
    normal_z = w.nz;
    start = 1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
  endtask

  task automatic quiesce();
    @(negedge clk);
    start = 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_write = 0;
  endtask

  function automatic word_t plain(logic [1:0] req);
    word_t w;
    w.req = req;
    foreach (w.v[k]) w.v[k] = 0;
    w.color = 0;
    w.nz = 16384;
    return w;
  endfunction

  // triangle from corner coordinates, z fixed at 0
  function automatic word_t facet(longint ax, ay, bx, by, cx, cy, logic [23:0] col);
    word_t w;
    w = plain(REQ_LOAD);
    w.v[0] = ax; w.v[1] = ay; w.v[3] = bx; w.v[4] = by; w.v[6] = cx; w.v[7] = cy;
    w.color = col;
    return w;
  endfunction

  function automatic word_t rand_load(bit wild);
    word_t w;
    int r;
    w = plain(REQ_LOAD);
    foreach (w.v[k]) w.v[k] = wild ? $urandom : int'($urandom_range(131072)) - 65536;
    if (!wild && $urandom_range(15) == 0) w.v[2] = $urandom_range(1) ? 65537 : -65537;
    w.color = $urandom;
    r = $urandom_range(9);
    if (r == 0) w.nz = $urandom;
    else if (r == 1) w.nz = -int'($urandom_range(16384, 13108));
    else w.nz = int'($urandom_range(29491)) - 13107;
    return w;
  endfunction

  function automatic word_t noise();
    word_t w;
    w = rand_load(1);
    w.req = $urandom;
    return w;
  endfunction

  initial begin
    word_t w;
    int sent;
    int n_load, n_shade;
    int pct[4] = '{0, 54, 0, 25};

    repeat (2) @(negedge clk);
    rst = 0;

    // directed: 2x2 frame, white background, ray (0,0) at pixel 1,1
    write_reg(CFG_WIDTH, 2);
    write_reg(CFG_HEIGHT, 2);
    write_reg(CFG_BG, 24'hFFFFFF);
    send(plain(REQ_CLEAR));
    send(facet(-65536, -65536, 65536, -65536, -65536, 65536, 24'h112233));
    send(facet(-65536, -65536, 65536, -65536, -65536, 65536, 24'h445566)); // depth tie
    send(facet(0, 0, 2, 0, 0, 2, 24'h0000AA));       // edge-on, skipped
    send(facet(-1, -1, 4, -1, -1, 0, 24'h0000BB));   // just above edge-on limit
    send(facet(0, 0, 100, 100, 200, 200, 24'h0000CC)); // collinear
    w = facet(-65536, -65536, 65536, 65536, -65536, 65536, 24'h00DD00);
    w.nz = CULL_NZ;                                     // culled at the limit
    send(w);
    w.nz = CULL_NZ + 1;
    w.v[2] = -65536; w.v[5] = 65536; w.v[8] = 0;        // kept, sloped depth
    send(w);
    w.nz = -16384;
    send(w);
    w = facet(-65536, -65536, 65536, -65536, -65536, 65536, 24'hEE0000);
    w.v[5] = 65537;                                     // depth out of range
    send(w);
    send(facet(70000, 70000, 90000, 70000, 70000, 90000, 24'h00EE00)); // off cube
    w = plain(REQ_LOAD);
    foreach (w.v[k]) w.v[k] = 24'hFFFFFF;
    w.color = 24'hFFFFFF;
    w.nz = -1;
    send(w);
    w = plain(2'd3);
    foreach (w.v[k]) w.v[k] = 24'h7FFFFF;
    send(w);
    repeat (5) send(plain(REQ_SHADE));  // walk wraps after four pixels

    // full store: later loads are dropped
    send(plain(REQ_CLEAR));
    for (int i = 0; i < MAX_TRIANGLES_DEF + 3; i++)
      send(facet(-65536, -65536, 65536, -65536, -65536, 65536, i));
    repeat (2) send(plain(REQ_SHADE));
    quiesce();

    // random phases, each under its own screen setting
    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = pct[ph % 4];
      case (ph)
        0: begin write_reg(CFG_WIDTH, 4); write_reg(CFG_HEIGHT, 4); end
        1: begin write_reg(CFG_WIDTH, 0); write_reg(CFG_HEIGHT, 0); end
        2: begin write_reg(CFG_WIDTH, 13'h1FFF); write_reg(CFG_HEIGHT, SIZE_MAX); end
        3: begin write_reg(CFG_WIDTH, 3); write_reg(CFG_HEIGHT, 5); end
        4: begin write_reg(CFG_WIDTH, 24'hFFE007); write_reg(CFG_HEIGHT, 2); end
        5: begin write_reg(CFG_WIDTH, 1); write_reg(CFG_HEIGHT, 3); end
        default: begin
          write_reg(CFG_WIDTH, $urandom_range(8, 1));
          write_reg(CFG_HEIGHT, $urandom_range(8, 1));
        end
      endcase
      write_reg(CFG_BG, (ph == 2) ? 24'h0 : $urandom);
      while (sent < (ph + 1) * 20) begin
        if ($urandom_range(4) != 0) begin
          send(plain(REQ_CLEAR));
          sent++;
        end
        n_load = $urandom_range(6);
        n_shade = $urandom_range(6, 1);
        repeat (n_load) begin
          send(rand_load($urandom_range(7) == 0));
          sent++;
        end
        repeat (n_shade) begin
          if ($urandom_range(9) == 0) begin
            send(noise());
            sent++;
          end
          send(plain(REQ_SHADE));
          sent++;
        end
      end
      quiesce();
    end

    if (fail_count == 0 && pending == 0)
      $display("** triangle_depth_pixel_shader: PASSED **");
    else
      $display("** triangle_depth_pixel_shader: FAILED **");
    $finish;
  end

endmodule

FILE: sim.f
design/tdps_pkg.sv
design/tdps_ram.sv
design/tdps_div.sv
design/tdps_dp.sv
design/tdps_ctrl.sv
design/triangle_depth_pixel_shader.sv
design/tdps_chk.sv
tb/tdps_checker.sv
tb/tb_top.sv
